@@ hdl/nlcc_pkg.sv @@
// Shared constants, types and helpers for the NMEA line checksum checker.
package nlcc_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int MAX_SCAN      = 75;
  localparam int COUNT_MAX     = (LINE_CAPACITY > MAX_SCAN) ? LINE_CAPACITY : MAX_SCAN;
  localparam int COUNT_W       = $clog2(COUNT_MAX + 1);

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  typedef logic [7:0]         byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SUM   = 3'd1,
    PH_DIG1  = 3'd2,
    PH_DIG2  = 3'd3,
    PH_HELD  = 3'd4,
    PH_FAIL  = 3'd5
  } phase_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
  } byte_stage_t;

  typedef struct packed {
    logic  valid;
    logic  ok;
    byte_t sum;
  } verdict_t;

  function automatic byte_t hex_upper(input logic [3:0] nib);
    byte_t ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

@@ hdl/nlcc_ifs.sv @@
// Valid/ready channel interfaces for received bytes and line verdicts.
interface nlcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nlcc_out_if;
  logic       valid;
  logic       ready;
  logic       sentence_ok;
  logic [7:0] computed_sum;
  modport source (output valid, output sentence_ok, output computed_sum, input ready);
  modport sink (input valid, input sentence_ok, input computed_sum, output ready);
endinterface

@@ hdl/nlcc_in_reg.sv @@
// Input register stage that holds one received byte request.
module nlcc_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data,
  output logic                in_ready,
  input  logic                take,
  output nlcc_pkg::byte_stage_t stage
);
  import nlcc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  byte_t data_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;
endmodule

@@ hdl/nlcc_scan.sv @@
// Line framing and checksum scanner that updates its state once per byte.
module nlcc_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nlcc_pkg::byte_stage_t stage,
  input  logic                  out_free,
  output logic                  take,
  output nlcc_pkg::verdict_t    verdict
);
  import nlcc_pkg::*;

  phase_t phase_r, phase_nxt;
  count_t count_r, count_nxt;
  byte_t  xor_r, xor_nxt;
  byte_t  dig1_r, dig1_nxt;
  byte_t  dig2_r, dig2_nxt;
  logic   line_end;
  byte_t  b;

  assign b        = stage.data;
  assign line_end = (b == CHAR_NEWLINE) || (int'(count_r) >= LINE_CAPACITY);
  assign take     = stage.valid && (!line_end || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      count_r <= '0;
      xor_r   <= '0;
      dig1_r  <= '0;
      dig2_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      dig1_r  <= dig1_nxt;
      dig2_r  <= dig2_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    dig1_nxt      = dig1_r;
    dig2_nxt      = dig2_r;
    verdict.valid = 1'b0;
    verdict.ok    = (phase_r == PH_HELD) && (dig1_r == hex_upper(xor_r[7:4]))
                    && (dig2_r == hex_upper(xor_r[3:0]));
    verdict.sum   = xor_r;
    if (take) begin
      if (line_end) begin
        verdict.valid = 1'b1;
        phase_nxt     = PH_START;
        count_nxt     = '0;
        xor_nxt       = '0;
        dig1_nxt      = '0;
        dig2_nxt      = '0;
      end else begin
        count_nxt = count_r + count_t'(1);
        unique case (phase_r)
          PH_START: begin
            phase_nxt = (b == CHAR_DOLLAR) ? PH_SUM : PH_FAIL;
          end
          PH_SUM: begin
            if ((int'(count_r) >= MAX_SCAN) || (b == CHAR_NUL)) begin
              phase_nxt = PH_FAIL;
            end else if (b == CHAR_STAR) begin
              phase_nxt = PH_DIG1;
            end else begin
              xor_nxt = xor_r ^ b;
            end
          end
          PH_DIG1: begin
            dig1_nxt  = b;
            phase_nxt = PH_DIG2;
          end
          PH_DIG2: begin
            dig2_nxt  = b;
            phase_nxt = PH_HELD;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end
endmodule

@@ hdl/nlcc_out_reg.sv @@
// Result register that holds one line verdict until it is taken.
module nlcc_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  nlcc_pkg::verdict_t verdict,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [7:0]         out_sum
);
  import nlcc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  logic  ok_r;
  byte_t sum_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = verdict.valid ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.valid) begin
      ok_r  <= verdict.ok;
      sum_r <= verdict.sum;
    end
  end

  assign out_valid = valid_r;
  assign out_ok    = ok_r;
  assign out_sum   = sum_r;
endmodule

@@ hdl/nmea_line_checksum_check.sv @@
// Top level of the NMEA line checksum checker.
// The block takes one received byte request per cycle and gives one verdict request
// per finished line, registered when the scan stage takes the newline or overflow byte.
// Throughput is one byte per cycle, set by the single scan stage between the input
// register and the result register; a line-ending byte waits in the input register
// only while the previous verdict is still held in the result register.
module nmea_line_checksum_check (
  input logic        clk,
  input logic        rst_n,
  nlcc_in_if.sink    in_chan,
  nlcc_out_if.source out_chan
);
  import nlcc_pkg::*;

  byte_stage_t stage;
  verdict_t    verdict;
  logic        take;
  logic        out_free;

  nlcc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_data  (in_chan.rx_byte),
    .in_ready (in_chan.ready),
    .take     (take),
    .stage    (stage)
  );

  nlcc_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .out_free (out_free),
    .take     (take),
    .verdict  (verdict)
  );

  nlcc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .verdict   (verdict),
    .out_free  (out_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_ok    (out_chan.sentence_ok),
    .out_sum   (out_chan.computed_sum)
  );
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the NMEA line checksum checker: framed lines in, verdicts compared.
module tb_top;
  import nlcc_pkg::*;

  typedef struct packed {
    logic  ok;
    byte_t sum;
  } line_verdict_t;

  logic clk;
  logic rst_n;

  nlcc_in_if  in_if ();
  nlcc_out_if out_if ();

  nmea_line_checksum_check dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  line_verdict_t verdicts_due[$];
  byte_t         line_buf[$];

  count_t line_len;
  phase_t scan_ph;
  byte_t  run_xor;
  byte_t  dig_hi;
  byte_t  dig_lo;

  bit steady;
  int hold_left;
  int bytes_sent;
  int lines_judged;
  int good_lines;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic byte_t hex_char(input logic [3:0] nib, input bit lower);
    string digits;
    digits = lower ? "0123456789abcdef" : "0123456789ABCDEF";
    return digits[nib];
  endfunction

  function automatic void clear_tracker();
    line_len = '0;
    scan_ph  = PH_START;
    run_xor  = 8'h00;
    dig_hi   = 8'h00;
    dig_lo   = 8'h00;
  endfunction

  // Follows the checker's on-the-fly scan and queues a verdict when a line closes.
  function automatic void track_line_byte(input byte_t b);
    line_verdict_t v;
    if (b != CHAR_NEWLINE && line_len < LINE_CAPACITY) begin
      case (scan_ph)
        PH_START: begin
          scan_ph = (b == CHAR_DOLLAR) ? PH_SUM : PH_FAIL;
        end
        PH_SUM: begin
          if (line_len >= MAX_SCAN || b == CHAR_NUL) begin
            scan_ph = PH_FAIL;
          end else if (b == CHAR_STAR) begin
            scan_ph = PH_DIG1;
          end else begin
            run_xor = run_xor ^ b;
          end
        end
        PH_DIG1: begin
          dig_hi  = b;
          scan_ph = PH_DIG2;
        end
        PH_DIG2: begin
          dig_lo  = b;
          scan_ph = PH_HELD;
        end
        default: begin
        end
      endcase
      line_len = line_len + 1'b1;
    end else begin
      v.ok  = (scan_ph == PH_HELD) && dig_hi == hex_char(run_xor[7:4], 1'b0)
              && dig_lo == hex_char(run_xor[3:0], 1'b0);
      v.sum = run_xor;
      verdicts_due.push_back(v);
      clear_tracker();
    end
  endfunction

  function automatic byte_t body_byte();
    byte_t b;
    do begin
      b = byte_t'($urandom_range(1, 255));
    end while (b == CHAR_NEWLINE || b == CHAR_STAR);
    return b;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_buf.push_back(byte_t'(s[i]));
    end
  endfunction

  function automatic void add_body(input int n);
    for (int i = 0; i < n; i++) begin
      line_buf.push_back(body_byte());
    end
  endfunction

  // Appends '*' and two hex digits for the XOR of everything after the first byte; corrupt flips the low digit.
  function automatic void add_checksum(input bit lower, input bit corrupt);
    byte_t x;
    byte_t lo;
    x = 8'h00;
    for (int i = 1; i < line_buf.size(); i++) begin
      x = x ^ line_buf[i];
    end
    lo = hex_char(x[3:0], lower);
    if (corrupt) begin
      lo = lo ^ 8'h01;
    end
    line_buf.push_back(CHAR_STAR);
    line_buf.push_back(hex_char(x[7:4], lower));
    line_buf.push_back(lo);
  endfunction

  task automatic send_byte(input byte_t b);
    if (!steady) begin
      while ($urandom_range(99) < 15) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    track_line_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_byte(line_buf[i]);
    end
    line_buf.delete();
  endtask

  task automatic wait_for_verdicts();
    in_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Sentence with a correct checksum over a random body; trailing bytes after the digits are ignored.
  task automatic send_sentence(input int body_len, input int tail_len);
    add_text("$");
    add_body(body_len);
    add_checksum(1'b0, 1'b0);
    add_body(tail_len);
    add_text("\n");
    send_line();
  endtask

  task automatic test_directed_lines();
    add_text("\n");
    send_line();
    add_text("$GPGGA,123519,4807.038,N,01131.000,E");
    add_checksum(1'b0, 1'b0);
    add_text("\r\n");
    send_line();
    add_text("$");
    add_checksum(1'b0, 1'b0);
    add_text("\n");
    send_line();
    add_text("$z");
    add_checksum(1'b1, 1'b0);
    add_text("\n");
    send_line();
    add_text("$GPGSV");
    add_checksum(1'b0, 1'b1);
    add_text("\n");
    send_line();
    add_text("GPGGA*00\n");
    send_line();
    add_text("$GP");
    line_buf.push_back(CHAR_NUL);
    add_text("A");
    add_checksum(1'b0, 1'b0);
    add_text("\n");
    send_line();
    add_text("$GPGGA\n");
    send_line();
    add_text("$AB*\n");
    send_line();
    add_text("$AB*0\n");
    send_line();
    line_buf.push_back(CHAR_DOLLAR);
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h01);
    line_buf.push_back(CHAR_DOLLAR);
    add_checksum(1'b0, 1'b0);
    add_text("\n");
    send_line();
    // Star as late as it may stand, then one place too late.
    add_text("$");
    add_body(MAX_SCAN - 2);
    add_checksum(1'b0, 1'b0);
    add_text("\n");
    send_line();
    add_text("$");
    add_body(MAX_SCAN - 1);
    add_checksum(1'b0, 1'b0);
    add_text("\n");
    send_line();
    // A full store closes the line on the next byte, which is dropped.
    add_text("$GPRMC,A");
    add_checksum(1'b0, 1'b0);
    add_body(LINE_CAPACITY - line_buf.size());
    add_text("X");
    send_line();
    add_text("$");
    add_body(LINE_CAPACITY - 1);
    add_text("\n");
    send_line();
    line_buf.push_back(CHAR_NUL);
    add_text("\n");
    send_line();
    wait_for_verdicts();
  endtask

  task automatic test_full_rate();
    steady = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_sentence($urandom_range(0, 12), $urandom_range(0, 2));
    end
    wait_for_verdicts();
    steady = 1'b0;
  endtask

  task automatic test_stalled_receiver();
    hold_left = 300;
    for (int i = 0; i < 12; i++) begin
      add_text("\n");
      send_line();
    end
    for (int i = 0; i < 4; i++) begin
      send_sentence($urandom_range(0, 10), 0);
    end
    wait_for_verdicts();
  endtask

  task automatic test_random_lines();
    int kind;
    int n;
    while (bytes_sent < 850) begin
      kind = $urandom_range(99);
      n = ($urandom_range(99) < 8) ? $urandom_range(20, 80) : $urandom_range(0, 16);
      if (kind < 55) begin
        send_sentence(n, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      end else if (kind < 75) begin
        add_text((kind < 72) ? "$" : "#");
        add_body(n);
        if (kind < 67) begin
          line_buf.insert($urandom_range(1, line_buf.size()), CHAR_NUL);
        end
        add_checksum(kind >= 62 && kind < 67, kind < 62);
        if (kind >= 67 && kind < 72) begin
          n = $urandom_range(0, line_buf.size() - 1);
          while (line_buf.size() > n) begin
            void'(line_buf.pop_back());
          end
        end
        add_text("\n");
        send_line();
      end else if (kind < 84) begin
        add_text("$");
        add_body($urandom_range(MAX_SCAN - 4, MAX_SCAN + 2));
        add_checksum(1'b0, 1'b0);
        add_text("\n");
        send_line();
      end else if (kind < 87) begin
        add_text("$");
        add_body($urandom_range(0, 20));
        add_checksum(1'b0, 1'b0);
        add_body(LINE_CAPACITY + 1 - line_buf.size());
        send_line();
      end else begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          line_buf.push_back(byte_t'($urandom_range(0, 255)));
        end
        add_text("\n");
        send_line();
      end
    end
    wait_for_verdicts();
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("verdict with none pending: ok=%0b sum=%02h",
                   out_if.sentence_ok, out_if.computed_sum);
        end
      end else begin
        if (out_if.sentence_ok !== verdicts_due[0].ok
            || out_if.computed_sum !== verdicts_due[0].sum) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("verdict mismatch: expected ok=%0b sum=%02h, got ok=%0b sum=%02h",
                     verdicts_due[0].ok, verdicts_due[0].sum,
                     out_if.sentence_ok, out_if.computed_sum);
          end
        end
        if (out_if.sentence_ok === 1'b1) begin
          good_lines++;
        end
        void'(verdicts_due.pop_front());
        lines_judged++;
      end
    end
  end

  initial begin
    steady        = 1'b0;
    hold_left     = 0;
    bytes_sent    = 0;
    lines_judged  = 0;
    good_lines    = 0;
    mismatches    = 0;
    clear_tracker();
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lines();
    test_full_rate();
    test_stalled_receiver();
    test_random_lines();
    wait_for_verdicts();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes; %0d line verdicts checked, %0d of them passing sentences.",
             bytes_sent, lines_judged, good_lines);
    $display("Mismatches: %0d; verdicts still pending: %0d.", mismatches, verdicts_due.size());
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/nlcc_pkg.sv
hdl/nlcc_ifs.sv
hdl/nlcc_in_reg.sv
hdl/nlcc_scan.sv
hdl/nlcc_out_reg.sv
hdl/nmea_line_checksum_check.sv
bench/tb_top.sv
